// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, held off while in reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds at a rising edge of clk.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) !(expr)) else $error(msg);

`endif

// ----- rtl/core/bsc_pkg.sv -----
package bsc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DATA_W    = 64;
    localparam int THR_W     = 31;
    localparam int SRC_W     = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register indexes of the configuration port
    localparam logic REG_BATCH_THRESHOLD = 1'b0;

    // Item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    typedef struct packed {
        logic              re;
        logic              we;
        logic              clear;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

endpackage

// ----- rtl/core/bsc_cfg.sv -----
module bsc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [bsc_pkg::THR_W-1:0]     threshold
);
    import bsc_pkg::*;

    logic [THR_W-1:0] threshold_reg;
    logic             sel_thr;
    logic             wr_en;

    assign pready  = 1'b1;
    assign sel_thr = (paddr[2] == REG_BATCH_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && pready && sel_thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_W'(1);
        end
        else if (wr_en)
        begin
            threshold_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata    = sel_thr ? PDATA_W'(threshold_reg) : '0;
    assign threshold = threshold_reg;

endmodule

// ----- rtl/core/bsc_stash_ram.sv -----
module bsc_stash_ram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsc_pkg::ram_req_t            req,
    output logic [bsc_pkg::DATA_W-1:0]   rd_stash
);
    import bsc_pkg::*;

    logic [DATA_W-1:0]    stash_mem [NUM_SLOTS];
    logic [DATA_W-1:0]    rdata_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            stash_mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= stash_mem[req.addr];
        end
    end

    // A slot that was never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_stash = rvalid_reg ? rdata_reg : '0;

endmodule

// ----- rtl/core/bsc_engine.sv -----
module bsc_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         kind,
    input  logic [bsc_pkg::SRC_W-1:0]    source_id,
    input  logic [bsc_pkg::DATA_W-1:0]   value,
    input  logic [bsc_pkg::THR_W-1:0]    threshold,
    input  logic [bsc_pkg::DATA_W-1:0]   rd_stash,
    output bsc_pkg::ram_req_t            ram_req,
    output logic                         busy,
    output logic                         done,
    output logic [bsc_pkg::DATA_W-1:0]   approx_total,
    output logic [bsc_pkg::DATA_W-1:0]   exact_total,
    output logic                         folded
);
    import bsc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0] stash_reg, stash_next;
    logic [DATA_W-1:0] global_reg, global_next;
    logic [DATA_W-1:0] running_reg, running_next;
    logic [DATA_W-1:0] approx_reg, approx_next;
    logic [DATA_W-1:0] exact_reg, exact_next;
    logic              folded_reg, folded_next;
    logic              done_reg, done_next;

    logic [SLOT_W-1:0] slot_in;
    logic [THR_W-1:0]  thr_eff;
    logic [DATA_W-1:0] magnitude;
    logic [DATA_W-1:0] global_sum;
    logic              fold;

    // Out-of-range sources share slot 0.
    assign slot_in = ({1'b0, source_id} < (SRC_W + 1)'(NUM_SLOTS)) ?
                     source_id[SLOT_W-1:0] : '0;

    assign thr_eff    = (threshold == '0) ? THR_W'(1) : threshold;
    assign magnitude  = stash_reg[DATA_W-1] ? (~stash_reg + DATA_W'(1)) : stash_reg;
    assign fold       = (magnitude >= DATA_W'(thr_eff));
    assign global_sum = global_reg + stash_reg;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        slot_next    = slot_reg;
        value_next   = value_reg;
        stash_next   = stash_reg;
        global_next  = global_reg;
        running_next = running_reg;
        approx_next  = approx_reg;
        exact_next   = exact_reg;
        folded_next  = folded_reg;
        done_next    = 1'b0;
        ram_req      = '0;
        ram_req.addr = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_req.addr = slot_in;
                if (start)
                begin
                    ram_req.re = 1'b1;
                    kind_next  = kind;
                    slot_next  = slot_in;
                    value_next = value;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (kind_reg == KIND_RESET)
                begin
                    ram_req.clear = 1'b1;
                    global_next   = value_reg;
                    running_next  = value_reg;
                    approx_next   = value_reg;
                    exact_next    = value_reg;
                    folded_next   = 1'b0;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    stash_next   = rd_stash + value_reg;
                    running_next = running_reg + value_reg;
                    state_next   = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = fold ? '0 : stash_reg;
                global_next   = fold ? global_sum : global_reg;
                approx_next   = fold ? global_sum : global_reg;
                exact_next    = running_reg;
                folded_next   = fold;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            global_reg  <= '0;
            running_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            global_reg  <= global_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        stash_reg  <= stash_next;
        approx_reg <= approx_next;
        exact_reg  <= exact_next;
        folded_reg <= folded_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign approx_total = approx_reg;
    assign exact_total  = exact_reg;
    assign folded       = folded_reg;

endmodule

// ----- rtl/core/batched_slot_counter_top.sv -----
// Sharded counter with one signed stash per source slot and one global total.
// Input channel: present kind, source_id and value with start; the transfer
// happens at a rising edge where start is high and busy is low. An add item
// adds value to the stash of its slot (sources beyond the slot count use
// slot 0) and folds the stash into the global total once its magnitude
// reaches batch_threshold. A reset item loads the global total and clears
// every stash.
// Result channel: done is high for one cycle with approx_total, exact_total
// and folded; the receiver cannot stall, so take the transfer in that cycle.
// Each item runs as passes through the single-port stash memory: a read, an
// add and a fold-writeback for an add item, a read and a clear for a reset
// item. busy covers the whole pass, so no two accesses to a slot overlap.
// Configuration: APB register batch_threshold at address 0 (31 bits, reset
// 1; zero acts as 1). Write it only while the block is idle.
// Reset: rst_n clears the global and running sums, but not approx_total and
// exact_total, and marks every stash as zero at once, with no clearing pass;
// the threshold returns to 1.
module batched_slot_counter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [bsc_pkg::SRC_W-1:0]     source_id,
    input  logic signed [63:0]            value,
    output logic                          done,
    output logic signed [63:0]            approx_total,
    output logic signed [63:0]            exact_total,
    output logic                          folded,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bsc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bsc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bsc_pkg::*;

    `include "assert_macros.svh"

    logic [THR_W-1:0]  threshold;
    logic [DATA_W-1:0] rd_stash;
    logic [DATA_W-1:0] approx_u;
    logic [DATA_W-1:0] exact_u;
    ram_req_t          ram_req;

    // Threshold register behind the APB port
    bsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // Per-slot stash storage with a registered read
    bsc_stash_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rd_stash (rd_stash)
    );

    // Read, add, fold and write back one item at a time
    bsc_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .source_id    (source_id),
        .value        (value),
        .threshold    (threshold),
        .rd_stash     (rd_stash),
        .ram_req      (ram_req),
        .busy         (busy),
        .done         (done),
        .approx_total (approx_u),
        .exact_total  (exact_u),
        .folded       (folded)
    );

    assign approx_total = approx_u;
    assign exact_total  = exact_u;

    `ASSERT_PROP(a_accept_busy, start && !busy |=> busy, "busy not raised after transfer")
    `ASSERT_PROP(a_wr_then_done, ram_req.we |=> done, "stash writeback without result")
    `ASSERT_PROP(a_wr_in_pass, ram_req.we |-> busy, "stash write outside an item")
    `ASSERT_NEVER(a_done_idle, done && busy, "result while busy")

endmodule
